// File: rtl/csvt_pkg.sv
`default_nettype none

package csvt_pkg;

  localparam logic [7:0] QUOTE_CHAR = 8'd34;
  localparam logic [7:0] CR_CHAR = 8'd13;
  localparam logic [7:0] LF_CHAR = 8'd10;
  localparam logic [7:0] NUL_CHAR = 8'd0;
  localparam logic [7:0] DELIM_RESET = 8'd44;

  // result queue, room for two results of one byte plus slack
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = RES_PTR_W + 1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       field_end;
    logic       record_end;
    logic       run_last;
  } out_item_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_CHAR   = 2'd1,
    ACT_FIELD  = 2'd2,
    ACT_RECORD = 2'd3
  } act_e;

  // results caused by one input item
  typedef struct packed {
    logic [1:0] num;
    out_item_t  res0;
    out_item_t  res1;
  } parse_res_t;

endpackage

`default_nettype wire

// File: rtl/csvt_core.sv
`default_nettype none

module csvt_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [7:0]           cfg_wdata_i,
  input  wire logic                 take_i,
  input  wire csvt_pkg::in_item_t   in_i,
  output csvt_pkg::parse_res_t      res_o
);
  import csvt_pkg::*;

  logic [7:0] delim_q;
  logic       quoted_q, quoted_d;
  logic       pending_q, pending_d;
  logic       empty_q, empty_d;
  logic       done_q, done_d;

  always_comb begin
    logic [7:0] b;
    logic       last;
    logic       do_class;
    act_e       act;
    b = in_i.data_byte;
    last = in_i.line_last;
    do_class = 1'b0;
    act = ACT_NONE;
    quoted_d = quoted_q;
    pending_d = pending_q;
    empty_d = empty_q;
    done_d = done_q;
    res_o = '0;

    if (!done_q) begin
      if (b == NUL_CHAR) begin
        pending_d = 1'b0;
        quoted_d = 1'b0;
        act = ACT_RECORD;
      end else if (pending_q) begin
        pending_d = 1'b0;
        if (b == QUOTE_CHAR) begin
          act = ACT_CHAR;
        end else begin
          quoted_d = 1'b0;
          do_class = 1'b1;
        end
      end else begin
        do_class = 1'b1;
      end

      if (do_class) begin
        if (!quoted_d && empty_q && b == QUOTE_CHAR) begin
          quoted_d = 1'b1;
          act = ACT_NONE;
        end else if (quoted_d && b == QUOTE_CHAR) begin
          // a quote on the last byte closes at once, otherwise wait for the next byte
          if (last) begin
            quoted_d = 1'b0;
          end else begin
            pending_d = 1'b1;
          end
          act = ACT_NONE;
        end else if (!quoted_d && b == delim_q) begin
          act = ACT_FIELD;
        end else if (!quoted_d && (b == CR_CHAR || b == LF_CHAR)) begin
          act = ACT_RECORD;
        end else begin
          act = ACT_CHAR;
        end
      end

      case (act)
        ACT_RECORD: begin
          res_o.num = 2'd1;
          res_o.res0.field_end = 1'b1;
          res_o.res0.record_end = 1'b1;
          done_d = 1'b1;
        end
        ACT_CHAR: begin
          res_o.num = 2'd1;
          res_o.res0.out_char = b;
          res_o.res0.char_valid = 1'b1;
          res_o.res0.field_end = last;
          res_o.res0.record_end = last;
          empty_d = 1'b0;
        end
        ACT_FIELD: begin
          res_o.num = last ? 2'd2 : 2'd1;
          res_o.res0.field_end = 1'b1;
          res_o.res1.field_end = last;
          res_o.res1.record_end = last;
          empty_d = 1'b1;
        end
        default: begin
          if (last) begin
            res_o.num = 2'd1;
            res_o.res0.field_end = 1'b1;
            res_o.res0.record_end = 1'b1;
          end
        end
      endcase

      if (res_o.num == 2'd1) begin
        res_o.res0.run_last = 1'b1;
      end
      if (res_o.num == 2'd2) begin
        res_o.res1.run_last = 1'b1;
      end
    end

    // last byte of a line always returns to start of line
    if (last) begin
      quoted_d = 1'b0;
      pending_d = 1'b0;
      empty_d = 1'b1;
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
      quoted_q <= 1'b0;
      pending_q <= 1'b0;
      empty_q <= 1'b1;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        delim_q <= cfg_wdata_i;
      end
      if (take_i) begin
        quoted_q <= quoted_d;
        pending_q <= pending_d;
        empty_q <= empty_d;
        done_q <= done_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/csv_line_tokenizer_top.sv
// results of an accepted item are registered into the result queue, behind any earlier results
// throughput: one byte per cycle while the queue has room; a byte yields zero, one or
// two results, held in a four-entry result queue that drains one per unstalled cycle
// input is stalled while fewer than two queue entries are free
// reset (asynchronous, active low) empties the queue, restores the start-of-line
// state and sets the delimiter to comma
`default_nettype none

module csv_line_tokenizer_top (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [7:0]           cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire csvt_pkg::in_item_t   in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output csvt_pkg::out_item_t       out_o
);
  import csvt_pkg::*;

  logic                 take;
  logic                 pop;
  parse_res_t           res;
  out_item_t            queue_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic [RES_CNT_W-1:0] push_n;
  logic [RES_PTR_W-1:0] wr_ptr_nx;

  assign in_stall_o = cnt_q > RES_CNT_W'(RES_DEPTH - 2);
  assign take = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != '0;
  assign pop = out_valid_o && !out_stall_i;
  assign out_o = queue_q[rd_ptr_q];

  csvt_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .take_i     (take),
    .in_i       (in_i),
    .res_o      (res)
  );

  always_comb begin
    push_n = take ? RES_CNT_W'(res.num) : '0;
    wr_ptr_nx = wr_ptr_q + RES_PTR_W'(1);
    wr_ptr_d = wr_ptr_q + RES_PTR_W'(push_n);
    rd_ptr_d = rd_ptr_q + RES_PTR_W'(pop);
    cnt_d = cnt_q + push_n - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (take && res.num != 2'd0) begin
      queue_q[wr_ptr_q] <= res.res0;
    end
    if (take && res.num == 2'd2) begin
      queue_q[wr_ptr_nx] <= res.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/csvt_checker.sv
`default_nettype none

module csvt_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire csvt_pkg::out_item_t  out_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  // both results of one byte are queued together, so the second follows at once
  a_run_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_o.run_last |=> out_valid_o)
    else $error("result run broken");

  a_mark_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.char_valid |-> out_o.out_char == 8'd0 && out_o.field_end)
    else $error("mark item carries a character or no field end");

  a_record_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.record_end |-> out_o.field_end && out_o.run_last)
    else $error("record end without field end or not last of run");

endmodule

bind csv_line_tokenizer_top csvt_checker u_csvt_checker (.*);

`default_nettype wire

// File: tb/csv_token_checker.sv
module csv_token_checker
  import csvt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_i,
  output int        err_cnt_o,
  output int        pend_cnt_o,
  output int        res_cnt_o
);

  // shadow copy of the parser state and the delimiter register
  logic [7:0] delim;
  logic       in_quotes;
  logic       quote_wait;
  logic       fld_empty;
  logic       rec_done;

  out_item_t token_q[$];
  out_item_t exp_r;
  int        n_err = 0;
  int        n_res = 0;

  function automatic void line_reset();
    in_quotes  = 1'b0;
    quote_wait = 1'b0;
    fld_empty  = 1'b1;
    rec_done   = 1'b0;
  endfunction

  function automatic out_item_t make_token(logic [7:0] ch, logic cv, logic fe, logic re);
    out_item_t r;
    r.out_char   = ch;
    r.char_valid = cv;
    r.field_end  = fe;
    r.record_end = re;
    r.run_last   = 1'b0;
    return r;
  endfunction

  // quote rules first, then the delimiter, then cr and lf
  function automatic act_e classify_byte(logic [7:0] b, logic lst);
    if (!in_quotes && fld_empty && b == QUOTE_CHAR) begin
      in_quotes = 1'b1;
      return ACT_NONE;
    end
    if (in_quotes && b == QUOTE_CHAR) begin
      if (lst) in_quotes = 1'b0;
      else quote_wait = 1'b1;
      return ACT_NONE;
    end
    if (!in_quotes && b == delim) return ACT_FIELD;
    if (!in_quotes && (b == CR_CHAR || b == LF_CHAR)) return ACT_RECORD;
    return ACT_CHAR;
  endfunction

  task automatic predict_tokens(input in_item_t it);
    logic [7:0] b;
    logic       lst;
    act_e       act;
    out_item_t  res [2];
    int         n;
    b   = it.data_byte;
    lst = it.line_last;
    n   = 0;
    act = ACT_NONE;
    res[0] = '0;
    res[1] = '0;
    // rest of the line after a record end is dropped
    if (rec_done) begin
      if (lst) line_reset();
      return;
    end
    if (b == NUL_CHAR) begin
      quote_wait = 1'b0;
      in_quotes  = 1'b0;
      act        = ACT_RECORD;
    end else if (quote_wait) begin
      quote_wait = 1'b0;
      if (b == QUOTE_CHAR) begin
        act = ACT_CHAR;
      end else begin
        in_quotes = 1'b0;
        act = classify_byte(b, lst);
      end
    end else begin
      act = classify_byte(b, lst);
    end
    case (act)
      ACT_RECORD: begin
        res[n] = make_token(NUL_CHAR, 1'b0, 1'b1, 1'b1);
        n++;
        rec_done = 1'b1;
      end
      ACT_CHAR: begin
        res[n] = make_token(b, 1'b1, lst, lst);
        n++;
        fld_empty = 1'b0;
      end
      ACT_FIELD: begin
        res[n] = make_token(NUL_CHAR, 1'b0, 1'b1, 1'b0);
        n++;
        fld_empty = 1'b1;
        // delimiter as last byte leaves an empty closing field
        if (lst) begin
          res[n] = make_token(NUL_CHAR, 1'b0, 1'b1, 1'b1);
          n++;
        end
      end
      default: begin
        if (lst) begin
          res[n] = make_token(NUL_CHAR, 1'b0, 1'b1, 1'b1);
          n++;
        end
      end
    endcase
    if (lst) line_reset();
    if (n > 0) res[n-1].run_last = 1'b1;
    for (int k = 0; k < n; k++) token_q.insert(token_q.size(), res[k]);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_err++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim = DELIM_RESET;
      line_reset();
      token_q.delete();
      err_cnt_o  <= n_err;
      pend_cnt_o <= 0;
      res_cnt_o  <= 0;
    end else begin
      // results seen at this edge belong to earlier items
      if (out_valid_i && !out_stall_i) begin
        if (token_q.size() == 0) begin
          $error("unexpected result item: out_char %0d", out_i.out_char);
          n_err++;
        end else begin
          exp_r = token_q.pop_front();
          check_field("out_char", exp_r.out_char, out_i.out_char);
          check_field("char_valid", 8'(exp_r.char_valid), 8'(out_i.char_valid));
          check_field("field_end", 8'(exp_r.field_end), 8'(out_i.field_end));
          check_field("record_end", 8'(exp_r.record_end), 8'(out_i.record_end));
          check_field("run_last", 8'(exp_r.run_last), 8'(out_i.run_last));
          n_res++;
        end
      end
      if (cfg_we_i) delim = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predict_tokens(in_i);
      err_cnt_o  <= n_err;
      pend_cnt_o <= token_q.size();
      res_cnt_o  <= n_res;
    end
  end

endmodule

// File: tb/tb.sv
module tb;
  import csvt_pkg::*;

  localparam int N_PHASES   = 9;
  localparam int PHASE_ITEMS = 55;
  localparam int HOLD_CYCLES = 80;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;

  int err_cnt;
  int pend_cnt;
  int res_cnt;
  int n_sent = 0;
  int n_rx   = 0;

  logic [7:0] cur_delim = DELIM_RESET;
  logic [7:0] line_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  csv_line_tokenizer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_item)
  );

  csv_token_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_i        (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_i       (out_item),
    .err_cnt_o   (err_cnt),
    .pend_cnt_o  (pend_cnt),
    .res_cnt_o   (res_cnt)
  );

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    // idle-free stretch every fourth block of thirty items
    gap = ((n_sent / 30) % 4 == 3) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_byte: b, line_last: lst};
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    n_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // stop offering and let every expected result drain out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pend_cnt != 0 || out_valid) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_delim(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_delim = v;
  endtask

  function automatic void add_byte(input logic [7:0] c);
    line_q.insert(line_q.size(), c);
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0: return QUOTE_CHAR;
      1: return cur_delim;
      2: return CR_CHAR;
      3: return LF_CHAR;
      4: return NUL_CHAR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] text_byte(input logic quoted);
    logic [7:0] c;
    if (quoted) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: return QUOTE_CHAR;
        4, 5, 6:    return cur_delim;
        7:          return CR_CHAR;
        8:          return LF_CHAR;
        default:    return 8'($urandom_range(1, 255));
      endcase
    end
    do c = 8'($urandom_range(1, 255));
    while (c == QUOTE_CHAR || c == cur_delim || c == CR_CHAR || c == LF_CHAR);
    return c;
  endfunction

  // mostly well-formed lines with random content, a quarter raw noise
  task automatic gen_line();
    int nf;
    int len;
    logic [7:0] c;
    line_q.delete();
    if ($urandom_range(0, 3) == 0) begin
      len = $urandom_range(1, 10);
      repeat (len) add_byte(noise_byte());
    end else begin
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
        if (f > 0) add_byte(cur_delim);
        len = $urandom_range(0, 4);
        if ($urandom_range(0, 1) == 1) begin
          add_byte(QUOTE_CHAR);
          repeat (len) begin
            c = text_byte(1'b1);
            add_byte(c);
            if (c == QUOTE_CHAR) add_byte(QUOTE_CHAR);
          end
          add_byte(QUOTE_CHAR);
        end else begin
          repeat (len) add_byte(text_byte(1'b0));
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        add_byte(($urandom_range(0, 1) == 1) ? CR_CHAR : LF_CHAR);
        repeat ($urandom_range(0, 2)) add_byte(noise_byte());
      end
    end
    if (line_q.size() == 0) add_byte(text_byte(1'b0));
  endtask

  // receiver: random stall per item, plus two long hold-offs to fill the block
  initial begin : rx_proc
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = ((n_rx / 30) % 4 == 1) ? 0 : $urandom_range(0, 4);
      if (n_rx == 120 || n_rx == 350) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
      n_rx++;
    end
  end

  initial begin : stim_proc
    logic [7:0] delim_tab [N_PHASES];
    int phase_n;
    delim_tab = '{8'd44, 8'd255, 8'd0, 8'd9, 8'd34, 8'd13, 8'd10, 8'd0, 8'd44};
    delim_tab[7] = 8'($urandom_range(0, 255));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines under the reset delimiter
    send_str("a,\"b\"\"c\",");      // doubled quote, delimiter as last byte
    send_str("x\nyz");              // lf ends record, rest of line ignored
    send_byte(QUOTE_CHAR, 1'b0);    // zero byte inside quotes
    send_byte("q", 1'b0);
    send_byte(NUL_CHAR, 1'b0);
    send_byte("r", 1'b1);
    send_str("\"k\"");              // closing quote on the last byte
    send_str("\"\"\"\"");           // quoted field holding one literal quote
    send_byte(8'hff, 1'b0);
    send_byte(NUL_CHAR, 1'b1);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        drain_results();
        write_delim(delim_tab[p]);
      end
      phase_n = 0;
      while (phase_n < PHASE_ITEMS) begin
        gen_line();
        for (int i = 0; i < line_q.size(); i++)
          send_byte(line_q[i], i == line_q.size() - 1);
        phase_n += line_q.size();
      end
    end
    drain_results();

    $display("summary: %0d bytes sent under %0d delimiter settings, %0d result items checked",
             n_sent, N_PHASES, res_cnt);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
